// ===== src/tsoc_pkg.sv =====
// Package for the two-sensor occupancy counter: types, reset values, channel update function.
package tsoc_pkg;

  localparam int unsigned DistW  = 10;
  localparam int unsigned RawW   = 11;
  localparam int unsigned HitsW  = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgAddrW = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgBaseValue  = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgCloseThr   = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgHitsNeeded = 2'd2;

  // Reset values of the configuration registers
  localparam logic [DistW-1:0] BaseValueRst  = 10'd85;
  localparam logic [DistW-1:0] CloseThrRst   = 10'd8;
  localparam logic [HitsW-1:0] HitsNeededRst = 4'd3;

  localparam logic signed [CountW-1:0] CountMax = 16'sh7FFF;
  localparam logic signed [CountW-1:0] CountMin = 16'sh8000;

  typedef struct packed {
    logic             armed;
    logic [HitsW-1:0] hits;
    logic             trig;
    logic             lock;
  } chan_t;

  typedef struct packed {
    logic [DistW-1:0] base_value;
    logic [DistW-1:0] close_threshold;
    logic [HitsW-1:0] hits_needed;
  } cfg_t;

  typedef struct packed {
    logic signed [CountW-1:0] occupancy;
    logic                     entered;
    logic                     exited;
  } res_t;

  // Arm / count phase of one channel
  function automatic chan_t chan_arm(chan_t c, logic close, logic [HitsW-1:0] hits_needed);
    chan_t            n;
    logic [HitsW-1:0] hits_inc;
    n        = c;
    hits_inc = c.hits + 4'd1;
    if (c.armed) begin
      if (close) begin
        n.hits = hits_inc;
        if (hits_inc >= hits_needed) begin
          n.trig  = 1'b1;
          n.armed = 1'b0;
          n.hits  = '0;
        end
      end else begin
        n.hits  = '0;
        n.armed = 1'b0;
        n.lock  = 1'b0;
      end
    end else if (close) begin
      n.lock  = 1'b1;
      n.armed = 1'b1;
    end
    return n;
  endfunction

endpackage

// ===== src/tsoc_step.sv =====
// Per-ping update: reading cleanup, channel sequencing and saturating count.
module tsoc_step
  import tsoc_pkg::*;
(
  input  cfg_t                      cfg,
  input  logic signed [RawW-1:0]    reading_a,
  input  logic                      valid_a,
  input  logic signed [RawW-1:0]    reading_b,
  input  logic                      valid_b,
  input  chan_t                     chan_a,
  input  chan_t                     chan_b,
  input  logic signed [CountW-1:0]  count,
  output chan_t                     chan_a_nxt,
  output chan_t                     chan_b_nxt,
  output res_t                      res
);

  logic [DistW-1:0] ra, rb;
  logic             close_a, close_b, clear;
  logic             done;
  logic signed [CountW-1:0] cnt;

  // Replace timeouts, negative and above-base readings with the base value
  always_comb begin
    if (!valid_a || reading_a[RawW-1] || (reading_a[DistW-1:0] > cfg.base_value)) begin
      ra = cfg.base_value;
    end else begin
      ra = reading_a[DistW-1:0];
    end
    if (!valid_b || reading_b[RawW-1] || (reading_b[DistW-1:0] > cfg.base_value)) begin
      rb = cfg.base_value;
    end else begin
      rb = reading_b[DistW-1:0];
    end
  end

  assign close_a = ra < cfg.close_threshold;
  assign close_b = rb < cfg.close_threshold;
  assign clear   = (ra > cfg.close_threshold) && (rb > cfg.close_threshold);

  // Channel a first if b is unlocked, channel b only if a did not end the ping and is unlocked
  always_comb begin
    chan_a_nxt = chan_a;
    chan_b_nxt = chan_b;
    cnt        = count;
    res        = '0;
    done       = 1'b0;
    if (!chan_b.lock) begin
      if (chan_a.trig) begin
        if (clear) begin
          if (count != CountMax) begin
            cnt = count + 16'sd1;
          end
          chan_a_nxt.trig = 1'b0;
          chan_a_nxt.lock = 1'b0;
          res.entered     = 1'b1;
        end
        done = 1'b1;
      end else begin
        chan_a_nxt = chan_arm(chan_a, close_a, cfg.hits_needed);
        done       = chan_a.armed;
      end
    end
    if (!done && !chan_a_nxt.lock) begin
      if (chan_b.trig) begin
        if (clear) begin
          if (count != CountMin) begin
            cnt = count - 16'sd1;
          end
          chan_b_nxt.trig = 1'b0;
          chan_b_nxt.lock = 1'b0;
          res.exited      = 1'b1;
        end
      end else begin
        chan_b_nxt = chan_arm(chan_b, close_b, cfg.hits_needed);
      end
    end
    res.occupancy = cnt;
  end

endmodule

// ===== src/two_sensor_occupancy_counter.sv =====
// Top level of the two-sensor doorway occupancy counter.
// A result beat is registered in the output register, or in the skid register while out_tready is low.
// Throughput: one ping per cycle while in_tready is high; the whole update is one pass of tsoc_step logic.
// A skid register lets one more ping be accepted while out_tready is low.
// Reset (rst_n low, synchronous): channel state and count clear, config returns to
// base_value 85, close_threshold 8, hits_needed 3, both output registers empty.
module two_sensor_occupancy_counter
  import tsoc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CfgAddrW-1:0]  cfg_addr,
  input  logic [DistW-1:0]     cfg_wdata,
  // input beats
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // reading_a[10:0], reading_b[21:11], zero pad
  input  logic [1:0]           in_tuser,   // valid_a[0], valid_b[1]
  // result beats
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata,  // occupancy[15:0]
  output logic [1:0]           out_tuser   // entered[0], exited[1]
);

  cfg_t  cfg_r;
  chan_t chan_a_r, chan_b_r, chan_a_nxt, chan_b_nxt;
  logic signed [CountW-1:0] count_r;
  res_t  res_nxt, out_r, skid_r;
  logic  out_valid_r, skid_valid_r;
  logic  in_acc, out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_value      <= BaseValueRst;
      cfg_r.close_threshold <= CloseThrRst;
      cfg_r.hits_needed     <= HitsNeededRst;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgBaseValue:  cfg_r.base_value      <= cfg_wdata;
        CfgCloseThr:   cfg_r.close_threshold <= cfg_wdata;
        CfgHitsNeeded: cfg_r.hits_needed     <= cfg_wdata[HitsW-1:0];
        default: ;
      endcase
    end
  end

  tsoc_step u_step (
    .cfg        (cfg_r),
    .reading_a  (in_tdata[RawW-1:0]),
    .valid_a    (in_tuser[0]),
    .reading_b  (in_tdata[2*RawW-1:RawW]),
    .valid_b    (in_tuser[1]),
    .chan_a     (chan_a_r),
    .chan_b     (chan_b_r),
    .count      (count_r),
    .chan_a_nxt (chan_a_nxt),
    .chan_b_nxt (chan_b_nxt),
    .res        (res_nxt)
  );

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Channel state and count advance on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_a_r <= '0;
      chan_b_r <= '0;
      count_r  <= '0;
    end else if (in_acc) begin
      chan_a_r <= chan_a_nxt;
      chan_b_r <= chan_b_nxt;
      count_r  <= res_nxt.occupancy;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res_nxt;
      end
    end else if (in_acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.occupancy;
  assign out_tuser  = {out_r.exited, out_r.entered};

endmodule
